/* sv/skf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_pkg: shared constants for the scalar Kalman filter
// Parameter defaults, register indexes and register reset values.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_MEAS_ERR   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INIT_ERR   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PROC_NOISE = 2'd2;

    localparam logic [63:0] MEAS_ERR_RST   = 64'd65536;
    localparam logic [63:0] INIT_ERR_RST   = 64'd65536;
    localparam logic [63:0] PROC_NOISE_RST = 64'd655;

endpackage

/* sv/skf_smul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_smul: bit-serial shift-add multiplier
// Unsigned i_a * i_b, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module skf_smul import skf_pkg::*; #(
    parameter int A_W = DATA_WIDTH_DEF + 1,
    parameter int B_W = FRAC_BITS_DEF + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_done,
    output logic [A_W+B_W-1:0] o_prod
);

    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

    logic [A_W-1:0]     r_a;
    logic [A_W+B_W-1:0] r_p;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [A_W:0]       w_sum;

    // partial product in the upper bits, unused multiplier bits shift out below
    assign w_sum = {1'b0, r_p[A_W+B_W-1:B_W]} + (r_p[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_p    <= {{A_W{1'b0}}, i_b};
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_p   <= {w_sum, r_p[B_W-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

/* sv/skf_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_div: serial restoring divider for the gain
// floor(num * 2^FB / den) with num <= den, one quotient bit per cycle.
// A zero denominator gives a zero quotient.
// ----------------------------------------------------------------------------
module skf_div import skf_pkg::*; #(
    parameter int DW = DATA_WIDTH_DEF,
    parameter int FB = FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_num,
    input  logic [DW:0]   i_den,
    output logic          o_done,
    output logic [FB:0]   o_quot
);

    localparam int CNT_W = $clog2(FB + 1);

    logic [DW:0]      r_r;
    logic [DW:0]      r_den;
    logic [FB:0]      r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_zero;
    logic             r_busy;
    logic             r_done;
    logic [DW+1:0]    w_rs;
    logic [DW+1:0]    w_diff;
    logic             w_ge;

    // integer bit first (no shift), then FB fraction bits
    assign w_rs   = (r_cnt == '0) ? {1'b0, r_r} : {r_r, 1'b0};
    assign w_diff = w_rs - {1'b0, r_den};
    assign w_ge   = (w_rs >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_zero <= 1'b0;
            r_q    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_r    <= {1'b0, i_num};
                r_den  <= i_den;
                r_zero <= (i_den == '0);
                r_q    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_r   <= w_ge ? w_diff[DW:0] : w_rs[DW:0];
                r_q   <= {r_q[FB-1:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FB)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : r_q;

endmodule

/* sv/scalar_kalman_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_filter: one-dimensional Kalman filter, fixed point
// Gain K = E / (E + M), estimate X += K * (z - X),
// error E = (1 - K) * E + |dX| * Q, saturating.
// ----------------------------------------------------------------------------
// channel   dir  fields (low bit first)                  transfer
// s_axis    in   measurement                             tvalid & tready
// m_axis    out  estimate, gain, estimate_error          tvalid & tready
// cfg       in   index / data (0 M, 1 E0, 2 Q)           i_cfg_we
//
// Each item passes the serial divider, the two gain multiplies (run side
// by side) and the process-noise multiply (DATA_WIDTH bits), one after
// the other.
// Reset is synchronous; no clearing pass, s_axis ready right after reset.
// A held result does not block the next transfer in; the result of that
// item waits in its last step until the output register frees up.
// ----------------------------------------------------------------------------
module scalar_kalman_filter import skf_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // measurement
    input  logic [((DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // estimate, gain, estimate_error, zero pad
    output logic [((2*DATA_WIDTH+FRAC_BITS+1+7)/8)*8-1:0] m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [DATA_WIDTH-1:0] i_cfg_data
);

    localparam int DW    = DATA_WIDTH;
    localparam int FB    = FRAC_BITS;
    localparam int OUT_W = ((2*DW+FB+1+7)/8)*8;
    localparam int PA_W  = DW + FB + 2;
    localparam int PB_W  = DW + FB + 1;
    localparam int PC_W  = 2*DW + 1;

    localparam logic [FB:0] ONE_K = (FB+1)'(1) << FB;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MULA = 3'd2;
    localparam logic [2:0] ST_STEP = 3'd3;
    localparam logic [2:0] ST_MULB = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [DW-1:0] r_meas_err;
    logic [DW-1:0] r_proc_noise;
    logic [DW-1:0] r_x;
    logic [DW-1:0] r_e;
    logic [FB:0]   r_k;
    logic [DW:0]   r_innov;
    logic          r_neg;
    logic [DW:0]   r_mag;
    logic [DW:0]   r_step;
    logic [DW-1:0] r_t1;
    logic [DW-1:0] r_t2;
    logic [DW-1:0] r_xn;
    logic          r_o_valid;
    logic [DW-1:0] r_o_est;
    logic [FB:0]   r_o_gain;
    logic [DW-1:0] r_o_err;

    logic          w_in_acc;
    logic          w_out_free;
    logic [DW-1:0] w_z;
    logic [DW:0]   w_innov;
    logic [DW:0]   w_den;
    logic          w_div_done;
    logic [FB:0]   w_quot;
    logic          w_mul_start;
    logic [FB:0]   w_one_minus_k;
    logic          w_ma_done;
    logic          w_mb_done;
    logic          w_mc_done;
    logic [PA_W-1:0] w_pa;
    logic [PB_W-1:0] w_pb;
    logic [PC_W-1:0] w_pc;
    logic [PA_W:0]   w_ra;
    logic [PB_W:0]   w_rb;
    logic [PC_W:0]   w_rc;
    logic [PA_W-FB:0] w_sa;
    logic [PB_W-FB:0] w_sb;
    logic [PC_W-FB:0] w_sc;
    logic [DW:0]   w_step;
    logic [DW-1:0] w_t1;
    logic [DW-1:0] w_t2;
    logic [DW:0]   w_sum;
    logic [DW-1:0] w_err;
    logic [DW:0]   w_xe;
    logic [DW:0]   w_xn;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;
    assign w_out_free    = !r_o_valid | m_axis_tready;

    assign w_z     = s_axis_tdata[DW-1:0];
    assign w_innov = {w_z[DW-1], w_z} - {r_x[DW-1], r_x};
    assign w_den   = {1'b0, r_e} + {1'b0, r_meas_err};

    assign w_mul_start   = (r_state == ST_DIV) & w_div_done;
    assign w_one_minus_k = ONE_K - w_quot;

    skf_div #(
        .DW (DW),
        .FB (FB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_acc),
        .i_num   (r_e),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // |innovation| * K
    skf_smul #(
        .A_W (DW + 1),
        .B_W (FB + 1)
    ) u_mul_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (r_mag),
        .i_b     (w_quot),
        .o_done  (w_ma_done),
        .o_prod  (w_pa)
    );

    // E * (1 - K)
    skf_smul #(
        .A_W (DW),
        .B_W (FB + 1)
    ) u_mul_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (r_e),
        .i_b     (w_one_minus_k),
        .o_done  (w_mb_done),
        .o_prod  (w_pb)
    );

    // |dX| * Q
    skf_smul #(
        .A_W (DW + 1),
        .B_W (DW)
    ) u_mul_noise (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_STEP),
        .i_a     (r_step),
        .i_b     (r_proc_noise),
        .o_done  (w_mc_done),
        .o_prod  (w_pc)
    );

    // round half up, then drop FB fraction bits
    assign w_ra = {1'b0, w_pa} + ((PA_W+1)'(1) << (FB - 1));
    assign w_rb = {1'b0, w_pb} + ((PB_W+1)'(1) << (FB - 1));
    assign w_rc = {1'b0, w_pc} + ((PC_W+1)'(1) << (FB - 1));
    assign w_sa = w_ra[PA_W:FB];
    assign w_sb = w_rb[PB_W:FB];
    assign w_sc = w_rc[PC_W:FB];

    assign w_step = (w_sa > {2'b00, r_mag}) ? r_mag : w_sa[DW:0];
    assign w_t1   = (|w_sb[PB_W-FB:DW]) ? '1 : w_sb[DW-1:0];
    assign w_t2   = (|w_sc[PC_W-FB:DW]) ? '1 : w_sc[DW-1:0];

    assign w_sum = {1'b0, r_t1} + {1'b0, r_t2};
    assign w_err = w_sum[DW] ? '1 : w_sum[DW-1:0];

    // new estimate lies between X and z, so the low DW bits are exact
    assign w_xe = {r_x[DW-1], r_x};
    assign w_xn = r_neg ? (w_xe - r_step) : (w_xe + r_step);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_in_acc)    n_state = ST_DIV;
            ST_DIV:  if (w_div_done)  n_state = ST_MULA;
            ST_MULA: if (w_ma_done)   n_state = ST_STEP;
            ST_STEP:                  n_state = ST_MULB;
            ST_MULB: if (w_mc_done)   n_state = ST_DONE;
            ST_DONE: if (w_out_free)  n_state = ST_IDLE;
            default:                  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_meas_err   <= MEAS_ERR_RST[DW-1:0];
            r_proc_noise <= PROC_NOISE_RST[DW-1:0];
            r_x          <= '0;
            r_e          <= INIT_ERR_RST[DW-1:0];
            r_k          <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_in_acc) begin
                r_innov <= w_innov;
            end
            if (r_state == ST_DIV) begin
                r_neg <= r_innov[DW];
                r_mag <= r_innov[DW] ? (~r_innov + 1'b1) : r_innov;
            end
            if (w_mul_start) begin
                r_k <= w_quot;
            end
            if ((r_state == ST_MULA) && w_ma_done) begin
                r_step <= w_step;
                r_t1   <= w_t1;
            end
            if (r_state == ST_STEP) begin
                r_xn <= w_xn[DW-1:0];
            end
            if ((r_state == ST_MULB) && w_mc_done) begin
                r_t2 <= w_t2;
            end

            if ((r_state == ST_DONE) && w_out_free) begin
                r_o_valid <= 1'b1;
                r_o_est   <= r_xn;
                r_o_gain  <= r_k;
                r_o_err   <= w_err;
                r_x       <= r_xn;
                r_e       <= w_err;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_MEAS_ERR:   r_meas_err   <= i_cfg_data;
                    REG_INIT_ERR:   r_e          <= i_cfg_data;
                    REG_PROC_NOISE: r_proc_noise <= i_cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = OUT_W'({r_o_err, r_o_gain, r_o_est});

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide step");

    a_gain_muls_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ma_done == w_mb_done)
        else $error("gain multipliers out of step");

    a_gain_at_most_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_gain <= ONE_K))
        else $error("gain above one");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result presented without finishing an item");

endmodule
